### src/ccpp_pkg.sv
package ccpp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TAG     = 3'd1,
        PH_FIELDS  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_STOP    = 3'd4
    } t_phase;

    // Result kinds
    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_UTF8    = 3'd1;
    localparam logic [2:0] KIND_INTEGER = 3'd2;
    localparam logic [2:0] KIND_CLASS   = 3'd3;
    localparam logic [2:0] KIND_METHOD  = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    // Constant pool tags
    localparam logic [7:0] TAG_UTF8    = 8'd1;
    localparam logic [7:0] TAG_INTEGER = 8'd3;
    localparam logic [7:0] TAG_CLASS   = 8'd7;
    localparam logic [7:0] TAG_METHOD  = 8'd10;

    // Header layout: last byte index of each field
    localparam logic [3:0] HDR_MAGIC_END = 4'd3;
    localparam logic [3:0] HDR_MINOR_END = 4'd5;
    localparam logic [3:0] HDR_MAJOR_END = 4'd7;
    localparam logic [3:0] HDR_LAST      = 4'd9;

    localparam logic [16:0] VERSION_BASE = 17'd44;
    localparam logic [15:0] LIMIT_RESET  = 16'd4;

    // Field bytes that follow a tag; zero for an unknown tag
    function automatic logic [2:0] field_bytes(input logic [7:0] tag);
        logic [2:0] n;
        case (tag)
            TAG_UTF8:    n = 3'd2;
            TAG_INTEGER: n = 3'd4;
            TAG_CLASS:   n = 3'd2;
            TAG_METHOD:  n = 3'd4;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    // Smaller of the limit and pool count minus one
    function automatic logic [15:0] target_count(input logic [15:0] limit,
                                                 input logic [15:0] pool);
        logic [15:0] avail;
        avail = (pool != 16'd0) ? pool - 16'd1 : 16'd0;
        return (limit < avail) ? limit : avail;
    endfunction

endpackage

### src/ccpp_in_if.sv
interface ccpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink   (input valid, input in_byte, input first_byte, output ready);
endinterface

### src/ccpp_out_if.sv
interface ccpp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [15:0]        entry_number;
    logic [7:0]         tag_value;
    logic [15:0]        first_value;
    logic [15:0]        second_value;
    logic signed [31:0] int_value;
    logic [31:0]        magic_number;
    logic signed [16:0] major_offset;
    logic               last_result;

    modport source (output valid, output kind, output entry_number, output tag_value,
                    output first_value, output second_value, output int_value,
                    output magic_number, output major_offset, output last_result,
                    input ready);
    modport sink   (input valid, input kind, input entry_number, input tag_value,
                    input first_value, input second_value, input int_value,
                    input magic_number, input major_offset, input last_result,
                    output ready);
endinterface

### src/class_constant_pool_parser.sv
// A word accepted into the input register is parsed, and any result word it
// gives is loaded into the result register (input register, then parse logic).
// Throughput: one input word per cycle; input stalls only while reset is held
// or the input register is full and a result waits for a sink that is not ready.
// Reset (i_rst_n low, synchronous): header phase, empty pipeline, entry limit 4.
module class_constant_pool_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    ccpp_in_if.sink       i_in,
    ccpp_out_if.source    o_out
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;

    // Parser state
    logic [15:0]           r_limit;
    ccpp_pkg::t_phase      r_phase, n_phase;
    logic [3:0]            r_hpos, n_hpos;
    logic [15:0]           r_fpos, n_fpos;
    logic [15:0]           r_done, n_done;
    logic [COUNT_BITS-1:0] r_pool, n_pool;
    logic [31:0]           r_gather, n_gather;
    logic [7:0]            r_tag, n_tag;
    logic [15:0]           r_minor, n_minor;

    // Result register
    logic               r_out_valid;
    logic [2:0]         r_kind, n_kind;
    logic [15:0]        r_num, n_num;
    logic [7:0]         r_tagv, n_tagv;
    logic [15:0]        r_first, n_first;
    logic [15:0]        r_second, n_second;
    logic signed [31:0] r_int, n_int;
    logic [31:0]        r_magic, n_magic;
    logic signed [16:0] r_jv, n_jv;
    logic               r_last, n_last;
    logic               n_emit;

    // Working values after a restart mark is applied
    ccpp_pkg::t_phase      e_phase;
    logic [3:0]            e_hpos;
    logic [15:0]           e_fpos;
    logic [15:0]           e_done;
    logic [COUNT_BITS-1:0] e_pool;
    logic [31:0]           e_gather;
    logic [15:0]           e_minor;
    logic [31:0]           shifted;
    logic [15:0]           fpos_inc;
    logic [15:0]           target;
    logic                  at_end;

    logic advance;

    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = i_rst_n && (!r_in_valid || advance);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ccpp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.in_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    // Parse one word
    always_comb begin
        e_phase  = r_in_first ? ccpp_pkg::PH_HEADER : r_phase;
        e_hpos   = r_in_first ? 4'd0 : r_hpos;
        e_fpos   = r_in_first ? 16'd0 : r_fpos;
        e_done   = r_in_first ? 16'd0 : r_done;
        e_pool   = r_in_first ? '0 : r_pool;
        e_gather = r_in_first ? 32'd0 : r_gather;
        e_minor  = r_in_first ? 16'd0 : r_minor;

        shifted  = {e_gather[23:0], r_in_byte};
        fpos_inc = e_fpos + 16'd1;
        target   = ccpp_pkg::target_count(r_limit, 16'(e_pool));
        at_end   = (e_done >= target);

        n_phase  = e_phase;
        n_hpos   = e_hpos;
        n_fpos   = e_fpos;
        n_done   = e_done;
        n_pool   = e_pool;
        n_gather = e_gather;
        n_tag    = r_in_first ? 8'd0 : r_tag;
        n_minor  = e_minor;

        n_emit   = 1'b0;
        n_kind   = ccpp_pkg::KIND_HEADER;
        n_num    = 16'd0;
        n_tagv   = 8'd0;
        n_first  = 16'd0;
        n_second = 16'd0;
        n_int    = 32'sd0;
        n_magic  = 32'd0;
        n_jv     = 17'sd0;
        n_last   = 1'b0;

        unique case (e_phase)
            ccpp_pkg::PH_HEADER: begin
                // Collect header fields big-endian
                if (e_hpos <= ccpp_pkg::HDR_MAGIC_END) begin
                    n_gather = (e_hpos == 4'd0) ? {24'd0, r_in_byte} : shifted;
                end else if (e_hpos <= ccpp_pkg::HDR_MINOR_END) begin
                    n_minor = {e_minor[7:0], r_in_byte};
                end else if (e_hpos <= ccpp_pkg::HDR_MAJOR_END) begin
                    n_fpos = {e_fpos[7:0], r_in_byte};
                end else begin
                    n_pool = COUNT_BITS'({e_pool, r_in_byte});
                end
                if (e_hpos < ccpp_pkg::HDR_LAST) begin
                    n_hpos = e_hpos + 4'd1;
                end else begin
                    n_hpos   = 4'd0;
                    n_done   = 16'd0;
                    n_emit   = 1'b1;
                    n_last   = (ccpp_pkg::target_count(r_limit, 16'(n_pool)) == 16'd0);
                    n_kind   = ccpp_pkg::KIND_HEADER;
                    n_num    = 16'(n_pool);
                    n_first  = n_minor;
                    n_second = e_fpos;
                    n_magic  = n_gather;
                    n_jv     = signed'(17'(e_fpos) - ccpp_pkg::VERSION_BASE);
                    n_fpos   = 16'd0;
                    n_phase  = n_last ? ccpp_pkg::PH_STOP : ccpp_pkg::PH_TAG;
                end
            end
            ccpp_pkg::PH_TAG: begin
                // Start an entry
                n_done   = e_done + 16'd1;
                n_tag    = r_in_byte;
                n_gather = 32'd0;
                n_fpos   = 16'd0;
                if (ccpp_pkg::field_bytes(r_in_byte) == 3'd0) begin
                    n_emit  = 1'b1;
                    n_kind  = ccpp_pkg::KIND_UNKNOWN;
                    n_num   = n_done;
                    n_tagv  = r_in_byte;
                    n_last  = 1'b1;
                    n_phase = ccpp_pkg::PH_STOP;
                end else begin
                    n_phase = ccpp_pkg::PH_FIELDS;
                end
            end
            ccpp_pkg::PH_FIELDS: begin
                // Gather field bytes, report when complete
                n_gather = shifted;
                n_fpos   = fpos_inc;
                if (fpos_inc >= 16'(ccpp_pkg::field_bytes(r_tag))) begin
                    n_emit  = 1'b1;
                    n_num   = e_done;
                    n_tagv  = r_tag;
                    n_last  = at_end;
                    n_fpos  = 16'd0;
                    n_phase = at_end ? ccpp_pkg::PH_STOP : ccpp_pkg::PH_TAG;
                    case (r_tag)
                        ccpp_pkg::TAG_UTF8: begin
                            n_kind  = ccpp_pkg::KIND_UTF8;
                            n_first = shifted[15:0];
                            if (shifted[15:0] != 16'd0) begin
                                n_fpos  = shifted[15:0];
                                n_phase = ccpp_pkg::PH_PAYLOAD;
                            end
                        end
                        ccpp_pkg::TAG_INTEGER: begin
                            n_kind = ccpp_pkg::KIND_INTEGER;
                            n_int  = signed'(shifted);
                        end
                        ccpp_pkg::TAG_CLASS: begin
                            n_kind  = ccpp_pkg::KIND_CLASS;
                            n_first = shifted[15:0];
                        end
                        default: begin
                            n_kind   = ccpp_pkg::KIND_METHOD;
                            n_first  = shifted[31:16];
                            n_second = shifted[15:0];
                        end
                    endcase
                end
            end
            ccpp_pkg::PH_PAYLOAD: begin
                // Skip string bytes
                n_fpos = e_fpos - 16'd1;
                if (n_fpos == 16'd0) begin
                    n_phase = at_end ? ccpp_pkg::PH_STOP : ccpp_pkg::PH_TAG;
                end
            end
            default: begin
                // Stopped: drop words until the next restart mark
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ccpp_pkg::PH_HEADER;
            r_hpos   <= 4'd0;
            r_fpos   <= 16'd0;
            r_done   <= 16'd0;
            r_pool   <= '0;
            r_gather <= 32'd0;
            r_tag    <= 8'd0;
            r_minor  <= 16'd0;
        end else if (advance && r_in_valid) begin
            r_phase  <= n_phase;
            r_hpos   <= n_hpos;
            r_fpos   <= n_fpos;
            r_done   <= n_done;
            r_pool   <= n_pool;
            r_gather <= n_gather;
            r_tag    <= n_tag;
            r_minor  <= n_minor;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_emit;
        end
        if (advance && r_in_valid && n_emit) begin
            r_kind   <= n_kind;
            r_num    <= n_num;
            r_tagv   <= n_tagv;
            r_first  <= n_first;
            r_second <= n_second;
            r_int    <= n_int;
            r_magic  <= n_magic;
            r_jv     <= n_jv;
            r_last   <= n_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.entry_number = r_num;
    assign o_out.tag_value    = r_tagv;
    assign o_out.first_value  = r_first;
    assign o_out.second_value = r_second;
    assign o_out.int_value    = r_int;
    assign o_out.magic_number = r_magic;
    assign o_out.major_offset = r_jv;
    assign o_out.last_result  = r_last;

endmodule
